/* hdl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared payload types, commands and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    // One command passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_end;
    } t_cmd;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

endpackage

/* hdl/sha_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front part
// Accepts input beats, drops idle ones and queues commands for the back part.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sha_pkg::t_in_beat i_data,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output sha_pkg::t_cmd     o_cmd
);

    sha_pkg::t_cmd r_q [sha_pkg::QDEPTH];
    logic [sha_pkg::QAW-1:0] r_wp, r_rp;
    logic [sha_pkg::QAW:0]   r_cnt;
    logic push, pop, keep;

    assign o_stall     = (r_cnt == 3'(sha_pkg::QDEPTH));
    assign keep        = i_data.byte_present | i_data.end_of_message;
    assign push        = i_valid & ~o_stall & keep;
    assign pop         = i_cmd_pop & (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{data_byte: i_data.data_byte,
                           has_byte: i_data.byte_present,
                           is_end: i_data.end_of_message};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_cmd_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(sha_pkg::QDEPTH)) else $error("queue overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 3'd1)) else $error("count slip");
`endif

endmodule

/* hdl/sha_back.sv */
// ----------------------------------------------------------------------------
// SHA-256 back part
// Fills the block, runs one compression round per cycle, pads and emits.
// ----------------------------------------------------------------------------
module sha_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  sha_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output sha_pkg::t_out_beat o_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROUND = 6'b000010,
        S_FOLD  = 6'b000100,
        S_PAD   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_LEN   = 6'b100000
    } t_state;

    t_state       r_state;
    logic [31:0]  r_w [16];      // message schedule window, word 0 oldest
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [5:0]   r_fill, r_round;
    logic [63:0]  r_bits;
    logic         r_closing;     // compression belongs to message close
    logic         r_final;       // block being compressed is the length block
    logic [2:0]   r_oi;
    logic         r_ov;

    logic [31:0] s0, s1, wn, t1, t2, e, a;
    logic [3:0]  wsel;
    logic [31:0] wbyte;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
        e  = r_v[4];
        a  = r_v[0];
        t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::round_k(r_round) + r_w[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign wsel  = r_fill[5:2];
    assign o_cmd_pop = (r_state == S_IDLE) & i_cmd_valid;
    assign o_valid = r_ov;
    assign o_data  = '{digest_word: r_h[r_oi], word_index: r_oi,
                       last_word: (r_oi == 3'd7)};

    // Byte placed into its slot of the word under fill.
    always_comb begin
        wbyte = r_w[wsel];
        case (r_fill[1:0])
            2'd0: wbyte[31:24] = i_cmd.data_byte;
            2'd1: wbyte[23:16] = i_cmd.data_byte;
            2'd2: wbyte[15:8]  = i_cmd.data_byte;
            default: wbyte[7:0] = i_cmd.data_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_round   <= '0;
            r_closing <= 1'b0;
            r_final   <= 1'b0;
            r_ov      <= 1'b0;
            r_oi      <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_closing <= i_cmd.is_end;
                        if (i_cmd.has_byte) begin
                            r_w[wsel] <= wbyte;
                            r_bits    <= r_bits + 64'd8;
                            r_fill    <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_state <= S_ROUND;
                                r_final <= 1'b0;
                                r_round <= '0;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end else if (i_cmd.is_end) begin
                                r_state <= S_PAD;
                            end
                        end else if (i_cmd.is_end) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    // Mark byte goes at the fill position, zeros after it.
                    for (int i = 0; i < 16; i++) begin
                        if (4'(i) > wsel) r_w[i] <= '0;
                    end
                    case (r_fill[1:0])
                        2'd0: r_w[wsel] <= {sha_pkg::PAD_MARK, 24'h0};
                        2'd1: r_w[wsel] <= {r_w[wsel][31:24], sha_pkg::PAD_MARK, 16'h0};
                        2'd2: r_w[wsel] <= {r_w[wsel][31:16], sha_pkg::PAD_MARK, 8'h0};
                        default: r_w[wsel] <= {r_w[wsel][31:8], sha_pkg::PAD_MARK};
                    endcase
                    r_round <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_state <= S_ROUND;
                    if (r_fill < sha_pkg::LENGTH_POS) begin
                        r_w[14] <= r_bits[63:32];
                        r_w[15] <= r_bits[31:0];
                        r_final <= 1'b1;
                    end else begin
                        r_final <= 1'b0;
                    end
                end
                S_LEN: begin
                    for (int i = 0; i < 14; i++) r_w[i] <= '0;
                    r_w[14] <= r_bits[63:32];
                    r_w[15] <= r_bits[31:0];
                    r_final <= 1'b1;
                    r_round <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wn;
                    for (int i = 1; i < 8; i++) r_v[i] <= r_v[i-1];
                    r_v[4] <= r_v[3] + t1;
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (!r_closing) begin
                        r_state <= S_IDLE;
                        r_fill  <= '0;
                    end else if (r_final) begin
                        r_state <= S_EMIT;
                        r_ov    <= 1'b1;
                        r_oi    <= '0;
                    end else if (r_fill == '0) begin
                        // Full block just compressed: close on an empty block.
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_ov      <= 1'b0;
                            r_state   <= S_IDLE;
                            r_fill    <= '0;
                            r_bits    <= '0;
                            r_closing <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_ov_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_EMIT)) else $error("beat outside emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_oi))) else $error("beat lost");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE)) else $error("pop while busy");
`endif

endmodule

/* hdl/sha256_message_hasher_top.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-wide SHA-256 with padding; emits eight digest words per message.
// ----------------------------------------------------------------------------
// Bytes enter through a four-entry command queue and are taken one per cycle
// while the block fills. A full block costs 64 compression rounds on one
// shared round unit plus a fold, during which the queue stalls once full.
// An end beat adds one or two padding compressions and then eight output
// beats, one per cycle when not stalled. Idle beats are dropped at the queue
// input.
module sha256_message_hasher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sha_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sha_pkg::t_out_beat  o_data
);

    logic          cmd_valid, cmd_pop;
    sha_pkg::t_cmd cmd;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd)
    );

    sha_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .i_cmd(cmd),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

endmodule

/* sim/sha256_digest_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels, hashes accepted bytes and compares digest beats.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_stall,
    input  sha_pkg::t_in_beat   i_data,
    input  logic                o_valid,
    input  logic                i_stall,
    input  sha_pkg::t_out_beat  o_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic [31:0]        hash_state [8];
    logic [7:0]         blk [64];
    int unsigned        fill;
    logic [63:0]        bit_len;
    sha_pkg::t_out_beat digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
        end
        r = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
               + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K_TAB[i] + w[i];
            t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
               + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += r[i];
    endtask

    task automatic absorb_beat(input sha_pkg::t_in_beat b);
        int unsigned        pos;
        sha_pkg::t_out_beat o;
        if (b.byte_present) begin
            blk[fill] = b.data_byte;
            bit_len += 64'd8;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (b.end_of_message) begin
            pos = fill;
            blk[pos] = sha_pkg::PAD_MARK;
            pos++;
            // Too little room for the length: flush a zero-filled block first.
            if (pos > sha_pkg::LENGTH_POS) begin
                for (int i = pos; i < 64; i++) blk[i] = 8'h00;
                compress();
                pos = 0;
            end
            for (int i = pos; i < sha_pkg::LENGTH_POS; i++) blk[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                blk[sha_pkg::LENGTH_POS + i] = bit_len[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_state[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_q = {digest_q, o};
            end
            hash_state = H_INIT;
            fill = 0;
            bit_len = '0;
        end
    endtask

    always @(posedge i_clk) begin
        sha_pkg::t_out_beat exp_beat;
        if (!i_rst_n) begin
            hash_state = H_INIT;
            fill = 0;
            bit_len = '0;
            digest_q.delete();
            o_fail_count = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: digest beat with none expected: got %h", $time, o_data);
                    o_fail_count++;
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (o_data !== exp_beat) begin
                        $display("%0t: digest beat expected %h/%0d/%0d got %h/%0d/%0d",
                                 $time, exp_beat.digest_word, exp_beat.word_index,
                                 exp_beat.last_word, o_data.digest_word,
                                 o_data.word_index, o_data.last_word);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) absorb_beat(i_data);
        end
        o_pending = digest_q.size();
    end
endmodule

/* sim/sha256_message_hasher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds directed and random messages with random idling on both channels.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    sha_pkg::t_in_beat  i_data;
    logic               o_valid;
    logic               i_stall;
    sha_pkg::t_out_beat o_data;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    bit                 quiet_tail;

    sha256_message_hasher_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    sha256_digest_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sha256_message_hasher_top: mismatch");
            $finish;
        end
    end

    // Receiver back-pressure in bursts.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Presents one beat and holds it until accepted.
    task automatic send_beat(input logic [7:0] b, input bit has, input bit fin);
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, byte_present: has, end_of_message: fin};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit end_with_byte);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
        if (!end_with_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        cycle_count = 0;
        quiet_tail  = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, field extremes, idle beats, pad boundaries.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b1, 1'b1);
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(64, 1'b1);

        // Random short messages.
        for (int m = 0; m < 20; m++) begin
            if (m == 16) quiet_tail = 1'b1;
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sha256_message_hasher_top: match");
        end else begin
            $display("sha256_message_hasher_top: mismatch");
        end
        $finish;
    end
endmodule
